>>> rtl/sba_pkg.sv
// package: shared types and constants for the segregated block allocator
package sba_pkg;

  localparam int NumClasses = 10;
  localparam int GranBits   = 13;
  localparam int LinkW      = 14;
  localparam int AddrW      = 16;
  localparam int SizeW      = 13;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusSize  = 2'd1;
  localparam logic [1:0] StatusNoMem = 2'd2;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  // classified request handed from front to back
  typedef struct packed {
    logic        is_free;
    logic        oversize;
    logic [3:0]  cls;
    logic [15:0] addr;
  } sba_cmd_t;

  // class of a byte size; NumClasses when too large
  function automatic logic [3:0] class_of(input logic [12:0] size);
    logic [3:0] c;
    c = 4'(NumClasses);
    for (int i = NumClasses - 1; i >= 0; i--) begin
      if ((14'd8 << i) >= {1'b0, size}) c = 4'(i);
    end
    return c;
  endfunction

  function automatic logic [13:0] block_size(input logic [3:0] c);
    return 14'd8 << c;
  endfunction

  function automatic logic is_excl(input logic [3:0] c);
    return c >= 4'd7;
  endfunction

endpackage

>>> rtl/sba_ram.sv
// generic single-port ram with registered read
module sba_ram #(
  parameter int Width = 14,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/sba_front.sv
// front end: accepts requests, classifies size into a command queue
module sba_front import sba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_req_type,
  input  logic [12:0] in_req_size,
  input  logic [15:0] in_block_addr,
  output logic       cmd_valid,
  output sba_cmd_t   cmd,
  input  logic       cmd_take
);
  sba_cmd_t q_r [2];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;
  sba_cmd_t nc;
  logic [3:0] c;

  always_comb begin
    c = class_of(in_req_size);
    nc.is_free  = (in_req_type == ReqFree);
    nc.oversize = (c == 4'(NumClasses));
    nc.cls      = c;
    nc.addr     = in_block_addr;
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_push && !in_full) q_r[wp_r] <= nc;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (in_push && !in_full) wp_r <= ~wp_r;
      if (cmd_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(in_push && !in_full) - 2'(cmd_take);
    end
  end
endmodule

>>> rtl/sba_back.sv
// back end: free lists, run carving, page refill and result register
module sba_back import sba_pkg::*; #(
  parameter int NumPages = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  sba_cmd_t   cmd,
  output logic       cmd_take,
  input  logic [4:0] page_limit,
  output logic       busy,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [1:0] out_status,
  output logic [15:0] out_alloc_addr
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POP   = 7'b0000010,
    S_EXCL  = 7'b0000100,
    S_SPRD  = 7'b0001000,
    S_DONE  = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_LINK  = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic [13:0] head_r [NumClasses];
  logic [15:0] run_start_r;
  logic [12:0] run_bytes_r;
  logic [3:0]  rot_r;
  logic [8:0]  pages_r;
  sba_cmd_t    cur_r;
  logic [15:0] a_r;      // walking address for refill / spread
  logic [12:0] rest_r;   // bytes remaining
  logic [1:0]  res_st_r;
  logic [15:0] res_addr_r;
  logic        full_r;

  logic        we;
  logic [12:0] ra;
  logic [13:0] wd, rd;

  sba_ram #(.Width(LinkW), .Depth(1 << GranBits)) u_link (
    .clk(clk), .we(we), .addr(ra), .wdata(wd), .rdata(rd));

  logic [8:0]  limit;
  logic        page_ok;
  logic [15:0] page_addr;
  logic [13:0] bs, sbs;
  logic [3:0]  rot_inc;
  logic        pop_hit;
  logic        run_carve;
  logic        done_now;

  always_comb begin
    limit     = ({4'd0, page_limit} < 9'(NumPages)) ? {4'd0, page_limit} : 9'(NumPages);
    page_ok   = pages_r < limit;
    page_addr = {pages_r[3:0], 12'd0};
    bs        = block_size(cur_r.cls);
    sbs       = block_size(rot_r);
    rot_inc   = (rot_r == 4'(NumClasses - 1)) ? 4'd0 : rot_r + 4'd1;
    pop_hit   = head_r[cur_r.cls][13];
    run_carve = ({1'b0, run_bytes_r} >= bs) && !is_excl(cur_r.cls);
    // result ready straight from the pop cycle, no refill walk
    done_now  = cur_r.oversize || cur_r.is_free || pop_hit || run_carve || !page_ok;
  end

  assign out_empty      = !full_r;
  assign out_status     = res_st_r;
  assign out_alloc_addr = res_addr_r;
  assign busy           = (st_r != S_IDLE) || full_r || cmd_valid;
  assign cmd_take       = (st_r == S_IDLE) && cmd_valid;

  // link store port
  always_comb begin
    we = 1'b0; ra = cmd.addr[15:3]; wd = head_r[cmd.cls];
    case (st_r)
      S_IDLE: begin
        if (cmd_valid && !cmd.oversize && cmd.is_free) begin
          we = 1'b1; ra = cmd.addr[15:3]; wd = head_r[cmd.cls];
        end else if (cmd_valid) begin
          ra = head_r[cmd.cls][12:0];
        end
      end
      S_EXCL: begin
        we = (rest_r >= bs[12:0]); ra = a_r[15:3]; wd = head_r[cur_r.cls];
      end
      S_SPRD: begin
        we = (rest_r >= 13'd8) && ({1'b0, sbs} <= {2'b0, rest_r}) && !is_excl(rot_r);
        ra = a_r[15:3]; wd = head_r[rot_r];
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (cmd_valid) st_nxt = S_POP;
      S_POP: begin
        if (done_now) st_nxt = S_WAIT;
        else if (is_excl(cur_r.cls)) st_nxt = S_EXCL;
        else st_nxt = S_SPRD;
      end
      S_LINK:  st_nxt = S_WAIT;
      S_EXCL:  if (rest_r < bs[12:0]) st_nxt = S_SPRD;
      S_SPRD:  if (rest_r < 13'd8) st_nxt = S_DONE;
      S_DONE:  st_nxt = S_WAIT;
      S_WAIT:  if (!full_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; full_r <= 1'b0;
      for (int i = 0; i < NumClasses; i++) head_r[i] <= '0;
      run_start_r <= '0; run_bytes_r <= '0; rot_r <= '0; pages_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (out_pop && full_r) full_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_r <= cmd;
            if (!cmd.oversize && cmd.is_free)
              head_r[cmd.cls] <= {1'b1, cmd.addr[15:3]};
          end
        end
        S_POP: begin
          if (cur_r.oversize) begin
            res_st_r <= StatusSize; res_addr_r <= '0;
          end else if (cur_r.is_free) begin
            res_st_r <= StatusOk; res_addr_r <= '0;
          end else if (pop_hit) begin
            res_st_r   <= StatusOk;
            res_addr_r <= {head_r[cur_r.cls][12:0], 3'd0};
            head_r[cur_r.cls] <= rd;
          end else if (run_carve) begin
            res_st_r    <= StatusOk;
            res_addr_r  <= run_start_r;
            run_start_r <= run_start_r + 16'(bs);
            run_bytes_r <= run_bytes_r - 13'(bs);
          end else if (!page_ok) begin
            res_st_r <= StatusNoMem; res_addr_r <= '0;
          end else begin
            res_st_r   <= StatusOk;
            res_addr_r <= page_addr;
            pages_r    <= pages_r + 9'd1;
            if (is_excl(cur_r.cls)) begin
              a_r    <= page_addr + 16'(bs);
              rest_r <= 13'(14'd4096 - bs);
            end else if ({1'b0, run_bytes_r} < 14'd4096 - bs) begin
              a_r <= run_start_r; rest_r <= run_bytes_r;
              run_start_r <= page_addr + 16'(bs);
              run_bytes_r <= 13'(14'd4096 - bs);
            end else begin
              a_r <= page_addr + 16'(bs); rest_r <= 13'(14'd4096 - bs);
            end
          end
          if (done_now) full_r <= 1'b1;
        end
        S_EXCL: begin
          if (rest_r >= bs[12:0]) begin
            head_r[cur_r.cls] <= {1'b1, a_r[15:3]};
            a_r <= a_r + 16'(bs); rest_r <= rest_r - bs[12:0];
          end
        end
        S_SPRD: begin
          if (rest_r >= 13'd8) begin
            if ({1'b0, sbs} <= {2'b0, rest_r} && !is_excl(rot_r)) begin
              head_r[rot_r] <= {1'b1, a_r[15:3]};
              a_r <= a_r + 16'(sbs); rest_r <= rest_r - sbs[12:0];
            end
            rot_r <= rot_inc;
          end
        end
        S_DONE: full_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/segregated_block_allocator.sv
// top level: segregated block allocator
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_push/in_full  | req_type, req_size, block_addr
//  out_    | output    | out_pop/out_empty| status, alloc_addr
//  cfg_    | input     | cfg_valid/ready  | page_limit
//
// a command moves from the front queue to the back end in the idle state
// a free, a list pop, a run carve or an error writes its result in the pop state
// a fresh page walks the exclusive refill, which stocks blocks of an exclusive class,
// then the spread walk over the classes; its result is released by the done state
// reset is synchronous; lists come up empty, link ram needs no clearing
// a full result register stalls the back end; the two-entry front queue then
// fills and raises in_full; cfg_ready is low while any transaction is in flight
module segregated_block_allocator import sba_pkg::*; #(
  parameter int NumPages = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_req_type,
  input  logic [12:0] in_req_size,
  input  logic [15:0] in_block_addr,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_status,
  output logic [15:0] out_alloc_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_page_limit
);
  logic       cmd_valid, cmd_take, busy;
  sba_cmd_t   cmd;
  logic [4:0] page_limit_r;

  // config register writable only while nothing is in flight
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) page_limit_r <= 5'd16;
    else if (cfg_valid && cfg_ready) page_limit_r <= cfg_page_limit;
  end

  sba_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_req_type, .in_req_size, .in_block_addr,
    .cmd_valid, .cmd, .cmd_take);

  sba_back #(.NumPages(NumPages)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_take, .page_limit(page_limit_r), .busy,
    .out_empty, .out_pop, .out_status, .out_alloc_addr);
endmodule

>>> rtl/sba_checker.sv
// checker: port-level properties of the allocator, bound to the top level
module sba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_status,
  input logic [15:0] out_alloc_addr
);
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status == 2'd0 || out_status == 2'd1 || out_status == 2'd2))
    else $error("bad status");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != 2'd0) |-> out_alloc_addr == 16'd0)
    else $error("addr not zero on error");
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_alloc_addr[2:0] == 3'd0)
    else $error("misaligned address");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_alloc_addr)))
    else $error("result dropped");
endmodule

bind segregated_block_allocator sba_checker u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_status, .out_alloc_addr);

>>> test/tb_segregated_block_allocator.sv
// testbench for the segregated block allocator: directed, random and back-pressure tests
module tb_segregated_block_allocator;
  import sba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2000000;
  localparam int DrainWait  = 600;
  localparam int PageSize   = 4096;
  localparam int ExclSize   = 1024;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_req_type;
  logic [12:0] in_req_size;
  logic [15:0] in_block_addr;
  logic        out_empty;
  logic        out_pop;
  logic [1:0]  out_status;
  logic [15:0] out_alloc_addr;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_page_limit;

  segregated_block_allocator uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_req_size    (in_req_size),
    .in_block_addr  (in_block_addr),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_alloc_addr (out_alloc_addr),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_page_limit (cfg_page_limit)
  );

  // 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // one expected result transaction
  typedef struct {
    logic [1:0]  status;
    logic [15:0] addr;
  } alloc_result_t;

  // a block handed out and not yet freed by the stimulus
  typedef struct {
    logic [15:0] addr;
    logic [12:0] size;
  } live_block_t;

  alloc_result_t pending_results[$];
  live_block_t   live_blocks[$];
  int            errors;
  int            cycles;

  // idling: chance in a hundred, per request for the sender, per pop decision for the receiver
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;   // receiver hold-off, counted down by the receiver itself

  // shadow of the allocator state
  logic [13:0] free_head[NumClasses];
  logic [13:0] link_mem[8192];
  logic [15:0] run_base;
  int          run_len;
  int          spread_pos;
  int          pages_taken;
  int          page_cap;

  // ---------------------------------------------------------------------------
  // allocator predictor
  // ---------------------------------------------------------------------------

  function automatic void push_free(input int c, input logic [15:0] a);
    logic [12:0] g;
    g = a[15:3];
    link_mem[g] = free_head[c];
    free_head[c] = {1'b1, g};
  endfunction

  // hand leftover bytes round-robin to the shared classes
  function automatic void scatter_leftover(input logic [15:0] a, input int bytes);
    int i;
    int bs;
    if (bytes == 0) return;
    i = spread_pos % NumClasses;
    while (bytes >= 8) begin
      bs = 8 << i;
      if (bs <= bytes && bs < ExclSize) begin
        push_free(i, a);
        a = a + 16'(bs);
        bytes -= bs;
      end
      i = (i + 1) % NumClasses;
    end
    spread_pos = i;
  endfunction

  function automatic bit claim_page(output logic [15:0] a);
    int cap;
    cap = page_cap < 16 ? page_cap : 16;
    a = '0;
    if (pages_taken >= cap) return 1'b0;
    a = 16'(pages_taken * PageSize);
    pages_taken++;
    return 1'b1;
  endfunction

  function automatic bit refill_class(input int c, output logic [15:0] a);
    int          bs;
    int          rest;
    int          old_len;
    logic [15:0] page;
    logic [15:0] p;
    logic [15:0] old_base;
    bs = 8 << c;
    a = '0;
    if (run_len >= bs && bs < ExclSize) begin
      a = run_base;
      run_base = run_base + 16'(bs);
      run_len -= bs;
      return 1'b1;
    end
    if (!claim_page(page)) return 1'b0;
    a = page;
    if (bs >= ExclSize) begin
      // exclusive class stocks its own list from the page
      p = page + 16'(bs);
      rest = PageSize - bs;
      while (rest >= bs) begin
        push_free(c, p);
        p = p + 16'(bs);
        rest -= bs;
      end
      scatter_leftover(p, rest);
    end else if (run_len < PageSize - bs) begin
      // fresh page replaces the smaller run
      old_base = run_base;
      old_len  = run_len;
      run_base = page + 16'(bs);
      run_len  = PageSize - bs;
      scatter_leftover(old_base, old_len);
    end else begin
      scatter_leftover(page + 16'(bs), PageSize - bs);
    end
    return 1'b1;
  endfunction

  function automatic alloc_result_t predict_request(input logic kind, input logic [12:0] size,
                                                    input logic [15:0] baddr);
    alloc_result_t r;
    int            c;
    logic [12:0]   g;
    r.status = StatusOk;
    r.addr   = '0;
    c = NumClasses;
    for (int i = NumClasses - 1; i >= 0; i--) begin
      if ((8 << i) >= int'(size)) c = i;
    end
    if (c >= NumClasses) begin
      r.status = StatusSize;
    end else if (kind == ReqFree) begin
      push_free(c, baddr);
    end else if (free_head[c][13]) begin
      g = free_head[c][12:0];
      r.addr = {g, 3'b000};
      free_head[c] = link_mem[g];
    end else if (!refill_class(c, r.addr)) begin
      r.status = StatusNoMem;
      r.addr   = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request sender: called at a rising edge, returns at the accepting edge or, after a random gap, at a later edge
  // ---------------------------------------------------------------------------

  task automatic send_request(input logic kind, input logic [12:0] size,
                              input logic [15:0] baddr);
    logic          was_full;
    alloc_result_t r;
    live_block_t   b;
    in_push       <= 1'b1;
    in_req_type   <= kind;
    in_req_size   <= size;
    in_block_addr <= baddr;
    forever begin
      @(negedge clk);
      was_full = in_full;
      @(posedge clk);
      if (was_full === 1'b0) break;
    end
    r = predict_request(kind, size, baddr);
    pending_results.push_back(r);
    if (kind == ReqAlloc && r.status == StatusOk) begin
      b.addr = r.addr;
      b.size = size;
      live_blocks.push_back(b);
    end
    // random sender gap; no lowering when the next transaction follows at once
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic write_page_limit(input logic [4:0] v);
    logic rdy;
    cfg_valid      <= 1'b1;
    cfg_page_limit <= v;
    forever begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
      if (rdy === 1'b1) break;
    end
    cfg_valid <= 1'b0;
    page_cap = v;
  endtask

  // sender stays idle until every result has been taken
  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result receiver and checker
  // ---------------------------------------------------------------------------

  always begin : result_check
    logic          was_empty;
    logic          was_pop;
    logic [1:0]    got_status;
    logic [15:0]   got_addr;
    alloc_result_t want;
    @(negedge clk);
    was_empty  = out_empty;
    was_pop    = out_pop;
    got_status = out_status;
    got_addr   = out_alloc_addr;
    @(posedge clk);
    if (rst_n && was_pop && was_empty === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction status %0d addr %h",
                 $realtime, got_status, got_addr);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got_status !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $realtime, want.status, got_status);
          errors++;
        end
        if (got_addr !== want.addr) begin
          $display("%0t: alloc_addr mismatch expected %h actual %h",
                   $realtime, want.addr, got_addr);
          errors++;
        end
      end
    end
    // decide pop for the next cycle
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes of each field, every request kind and the special cases
  task automatic test_directed();
    write_page_limit(5'd1);
    send_request(ReqAlloc, 13'd0, 16'h0000);      // zero size lands in the 8-byte class
    send_request(ReqAlloc, 13'd1, 16'hFFFF);      // block_addr ignored for alloc
    send_request(ReqAlloc, 13'd9, 16'h0000);
    send_request(ReqAlloc, 13'd1024, 16'h0000);   // exclusive class wants a page: none left
    send_request(ReqAlloc, 13'd4096, 16'h0000);
    send_request(ReqAlloc, 13'd4097, 16'h0000);   // oversize alloc
    send_request(ReqFree, 13'd8191, 16'h1234);    // oversize free changes nothing
    send_request(ReqFree, 13'd8, 16'h0007);       // misaligned free drops low bits
    send_request(ReqAlloc, 13'd8, 16'h0000);
    send_request(ReqFree, 13'd4096, 16'hFFFF);    // top of address space
    send_request(ReqAlloc, 13'd4096, 16'h0000);
    send_request(ReqFree, 13'd1, 16'h5550);       // free of a block never handed out
    send_request(ReqAlloc, 13'd3, 16'h0000);
    wait_idle();
    write_page_limit(5'd16);
    send_request(ReqAlloc, 13'd1024, 16'h0000);   // exclusive refill
    send_request(ReqAlloc, 13'd1000, 16'h0000);
    send_request(ReqAlloc, 13'd2048, 16'h0000);
    send_request(ReqAlloc, 13'd4096, 16'h0000);
    send_request(ReqAlloc, 13'd512, 16'h0000);
    send_request(ReqAlloc, 13'd17, 16'h0000);
    send_request(ReqAlloc, 13'd256, 16'h0000);
    send_request(ReqFree, 13'd4095, 16'hAAA8);
    send_request(ReqAlloc, 13'd4095, 16'h0000);
    wait_idle();
  endtask

  function automatic logic [12:0] random_size();
    int r;
    r = $urandom_range(99);
    if (r < 2)  return 13'd0;
    if (r < 65) return 13'($urandom_range(1, 256));
    if (r < 85) return 13'($urandom_range(257, 1024));
    if (r < 96) return 13'($urandom_range(1025, 4096));
    return 13'($urandom_range(4097, 8191));
  endfunction

  // mostly allocs and frees of live blocks, some stray frees as noise
  task automatic random_request();
    int          r;
    int          k;
    live_block_t b;
    r = $urandom_range(99);
    if (r < 50 || live_blocks.size() == 0) begin
      send_request(ReqAlloc, random_size(), 16'($urandom));
    end else if (r < 95) begin
      k = $urandom_range(live_blocks.size() - 1);
      b = live_blocks[k];
      live_blocks.delete(k);
      send_request(ReqFree, b.size, b.addr);
    end else begin
      send_request(ReqFree, random_size(), 16'($urandom));
    end
  endtask

  task automatic test_random(input int count, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) random_request();
    wait_idle();
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 500;
    repeat (60) random_request();
    // sender pauses until every result is back
    wait_idle();
  endtask

  initial begin
    errors         = 0;
    cycles         = 0;
    hold_left      = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    run_base       = '0;
    run_len        = 0;
    spread_pos     = 0;
    pages_taken    = 0;
    page_cap       = 16;
    for (int i = 0; i < NumClasses; i++) free_head[i] = '0;
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_req_type    <= ReqAlloc;
    in_req_size    <= '0;
    in_block_addr  <= '0;
    out_pop        <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_page_limit <= 5'd16;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(280, 16, 48);
    write_page_limit(5'd7);     // below pages already taken: refills fail
    test_random(280, 48, 16);
    write_page_limit(5'd16);
    test_backpressure();
    test_random(260, 0, 0);

    repeat (DrainWait) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
